/* hdl/sdiv_pkg.sv */
// Package for the saturating signed divider.
// Holds the word width, the boundary operand and result values and the controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps

package sdiv_pkg;

  localparam int unsigned WIDTH = 32;
  localparam int unsigned CNT_W = $clog2(WIDTH);

  localparam logic [WIDTH-1:0] QUOT_MAX  = {1'b0, {(WIDTH-1){1'b1}}};
  localparam logic [WIDTH-1:0] MOST_NEG  = {1'b1, {(WIDTH-1){1'b0}}};
  localparam logic [WIDTH-1:0] MINUS_ONE = {WIDTH{1'b1}};

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture operands, magnitudes, sign and saturation flag
    logic step;    // one restoring-division iteration
    logic finish;  // apply sign or saturation and register the quotient
  } sdiv_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic last_step;  // the step in progress produces the final quotient bit
  } sdiv_stat_t;

endpackage

/* hdl/signed_divider_saturating.sv */
// Top level of the saturating 32-bit signed divider.
// Instantiates sdiv_ctrl and sdiv_dp; depends on sdiv_pkg.
//
//   Channel   Signals                        Direction  Transfer rule
//   command   start, busy, dividend, divisor in (busy out) accepted when start && !busy
//   result    done, quotient                 out        one cycle, cannot be held off
//
// The accepting edge loads the operands. The edges in S_RUN then run the
// restoring-division iterations on the single shared subtractor (one quotient
// bit each), and the edge in S_FIX applies the sign or saturation and raises
// done. The result transaction is taken at the first edge that can accept the
// next command. Reset is synchronous and active high; it returns the
// controller to idle and clears done. The receiver cannot stall: quotient is
// valid only in the cycle that done marks, and a new command may be accepted
// in that same cycle.
`timescale 1ns / 1ps

module signed_divider_saturating (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [sdiv_pkg::WIDTH-1:0] dividend,
  input  logic signed [sdiv_pkg::WIDTH-1:0] divisor,
  output logic                              done,
  output logic signed [sdiv_pkg::WIDTH-1:0] quotient
);

  // Commands and status are the only connection between the two halves.
  sdiv_pkg::sdiv_cmd_t  cmd;
  sdiv_pkg::sdiv_stat_t stat;

  // The controller counts nothing itself; the datapath reports the final
  // iteration so the step counter sits next to the shift registers it tracks.
  sdiv_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd),
    .stat  (stat)
  );

  // The datapath divides magnitudes; a zero divisor or the most negative
  // dividend over minus one yields the largest positive value instead.
  sdiv_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .dividend (dividend),
    .divisor  (divisor),
    .quotient (quotient)
  );

endmodule

/* hdl/sdiv_dp.sv */
// Datapath of the saturating signed divider: operand magnitudes, the partial
// remainder, the combined dividend/quotient shift register and the result register.
// Depends on sdiv_pkg.
`timescale 1ns / 1ps

module sdiv_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  sdiv_pkg::sdiv_cmd_t              cmd,
  output sdiv_pkg::sdiv_stat_t             stat,
  input  logic signed [sdiv_pkg::WIDTH-1:0] dividend,
  input  logic signed [sdiv_pkg::WIDTH-1:0] divisor,
  output logic signed [sdiv_pkg::WIDTH-1:0] quotient
);

  logic [sdiv_pkg::WIDTH-1:0] den;
  logic [sdiv_pkg::WIDTH-1:0] rem;
  logic [sdiv_pkg::WIDTH-1:0] nq;    // dividend bits shift out, quotient bits shift in
  logic                       neg;
  logic                       sat;
  logic [sdiv_pkg::CNT_W-1:0] count;

  logic [sdiv_pkg::WIDTH-1:0] a_mag;
  logic [sdiv_pkg::WIDTH-1:0] b_mag;
  logic [sdiv_pkg::WIDTH:0]   rem_sh;
  logic [sdiv_pkg::WIDTH:0]   diff;
  logic                       fits;

  always_comb begin
    a_mag  = dividend[sdiv_pkg::WIDTH-1] ? (~dividend + 1'b1) : dividend;
    b_mag  = divisor[sdiv_pkg::WIDTH-1] ? (~divisor + 1'b1) : divisor;
    rem_sh = {rem, nq[sdiv_pkg::WIDTH-1]};
    diff   = rem_sh - {1'b0, den};
    fits   = ~diff[sdiv_pkg::WIDTH];
  end

  assign stat.last_step = (count == sdiv_pkg::CNT_W'(sdiv_pkg::WIDTH - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.load) begin
      count <= '0;
    end else if (cmd.step) begin
      count <= count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      den <= b_mag;
      rem <= '0;
      nq  <= a_mag;
      neg <= dividend[sdiv_pkg::WIDTH-1] ^ divisor[sdiv_pkg::WIDTH-1];
      sat <= (divisor == '0) ||
             ((dividend == sdiv_pkg::MOST_NEG) && (divisor == sdiv_pkg::MINUS_ONE));
    end else if (cmd.step) begin
      // The remainder stays below the divisor magnitude, so it fits in WIDTH bits.
      rem <= fits ? diff[sdiv_pkg::WIDTH-1:0] : rem_sh[sdiv_pkg::WIDTH-1:0];
      nq  <= {nq[sdiv_pkg::WIDTH-2:0], fits};
    end
    if (cmd.finish) begin
      if (sat) begin
        quotient <= sdiv_pkg::QUOT_MAX;
      end else if (neg) begin
        quotient <= ~nq + 1'b1;
      end else begin
        quotient <= nq;
      end
    end
  end

endmodule

/* hdl/sdiv_ctrl.sv */
// Controller of the saturating signed divider: sequences load, the iteration
// steps and the final fixup, and drives busy and the result strobe.
// Depends on sdiv_pkg.
`timescale 1ns / 1ps

module sdiv_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  output logic                 done,
  output sdiv_pkg::sdiv_cmd_t  cmd,
  input  sdiv_pkg::sdiv_stat_t stat
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FIX
  } state_t;

  state_t state;

  assign busy       = (state != S_IDLE);
  assign cmd.load   = (state == S_IDLE) && start;
  assign cmd.step   = (state == S_RUN);
  assign cmd.finish = (state == S_FIX);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (stat.last_step) begin
            state <= S_FIX;
          end
        end
        S_FIX: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* test/tb_signed_divider_saturating.sv */
// Self-checking testbench for the saturating 32-bit signed divider.
// Drives directed and random divisions and checks each quotient against a local predictor.
// Depends on sdiv_pkg and signed_divider_saturating.
`timescale 1ns / 1ps

module tb_signed_divider_saturating;

  // One division as the scoreboard sees it: the operands that were accepted
  // and the quotient the block should return for them.
  typedef struct {
    logic signed [sdiv_pkg::WIDTH-1:0] dividend;
    logic signed [sdiv_pkg::WIDTH-1:0] divisor;
    logic signed [sdiv_pkg::WIDTH-1:0] quotient;
  } division_t;

  logic                              clk;
  logic                              rst      = 1'b1;
  logic                              start    = 1'b0;
  logic signed [sdiv_pkg::WIDTH-1:0] dividend = '0;
  logic signed [sdiv_pkg::WIDTH-1:0] divisor  = '0;
  logic                              busy;
  logic                              done;
  logic signed [sdiv_pkg::WIDTH-1:0] quotient;

  // Quotients still owed by the block, oldest first.
  division_t pending_quotients[$];

  // The sender inserts random idle bursts only while this is set.
  bit sender_idles = 1'b0;

  int divisions_sent    = 0;
  int quotients_checked = 0;
  int mismatch_count    = 0;
  int zero_divisors     = 0;
  int overflow_cases    = 0;

  signed_divider_saturating dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (done),
    .quotient (quotient)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Expected quotient of one division. A zero divisor and the single
  // overflowing case (most negative over minus one) both saturate to the
  // largest positive value. Otherwise the magnitudes go through a plain
  // restoring division, one quotient bit per pass from the top down, and the
  // sign of the result is the XOR of the operand signs.
  function automatic logic signed [sdiv_pkg::WIDTH-1:0] predict_quotient(
    input logic signed [sdiv_pkg::WIDTH-1:0] num,
    input logic signed [sdiv_pkg::WIDTH-1:0] den
  );
    logic [sdiv_pkg::WIDTH-1:0] num_mag;
    logic [sdiv_pkg::WIDTH-1:0] den_mag;
    logic [sdiv_pkg::WIDTH:0]   partial;
    logic [sdiv_pkg::WIDTH-1:0] q;
    if (den == '0 || (num == sdiv_pkg::MOST_NEG && den == sdiv_pkg::MINUS_ONE)) begin
      return sdiv_pkg::QUOT_MAX;
    end
    // Two's complement magnitude; the most negative value maps to 2^31,
    // which still fits in an unsigned 32-bit word.
    num_mag = num[sdiv_pkg::WIDTH-1] ? ('0 - num) : num;
    den_mag = den[sdiv_pkg::WIDTH-1] ? ('0 - den) : den;
    partial = '0;
    q       = '0;
    for (int bit_idx = sdiv_pkg::WIDTH - 1; bit_idx >= 0; bit_idx--) begin
      partial = {partial[sdiv_pkg::WIDTH-1:0], num_mag[bit_idx]};
      q = q << 1;
      if (partial >= {1'b0, den_mag}) begin
        partial = partial - {1'b0, den_mag};
        q[0]    = 1'b1;
      end
    end
    return (num[sdiv_pkg::WIDTH-1] ^ den[sdiv_pkg::WIDTH-1]) ? ('0 - q) : q;
  endfunction

  // Scoreboard. Both the command handshake and the result strobe are
  // sampled at the rising edge, so the values seen here are the ones that
  // held during the cycle that the edge closes. The result is checked before
  // a newly accepted command is queued, which keeps the order right when a
  // quotient comes out in the same cycle that the next command goes in.
  always @(posedge clk) begin
    division_t oldest;
    division_t accepted;
    if (!rst) begin
      if (done === 1'b1) begin
        if (pending_quotients.size() == 0) begin
          $error("unexpected result: quotient %0d with no division outstanding", quotient);
          mismatch_count++;
        end else begin
          oldest = pending_quotients.pop_front();
          quotients_checked++;
          if (quotient !== oldest.quotient) begin
            $error("quotient mismatch for %0d / %0d: expected %0d, actual %0d",
                   oldest.dividend, oldest.divisor, oldest.quotient, quotient);
            mismatch_count++;
          end
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        accepted.dividend = dividend;
        accepted.divisor  = divisor;
        accepted.quotient = predict_quotient(dividend, divisor);
        pending_quotients.push_back(accepted);
      end
    end
  end

  // Sends one division and returns at the edge where the block takes it.
  // Start is left high on return so that a following call can hand over the
  // next operands without a dead cycle; whoever stops sending lowers it.
  // An idle burst is counted from the moment the block is free again, so
  // the next command lands at varying distances from the previous result.
  task automatic send_division(input logic signed [sdiv_pkg::WIDTH-1:0] num,
                               input logic signed [sdiv_pkg::WIDTH-1:0] den);
    int gap;
    gap = 0;
    if (sender_idles && $urandom_range(0, 2) == 0) gap = $urandom_range(1, 13);
    if (gap > 0) begin
      start <= 1'b0;
      do @(posedge clk); while (busy !== 1'b0);
      repeat (gap - 1) @(posedge clk);
    end
    start    <= 1'b1;
    dividend <= num;
    divisor  <= den;
    do @(posedge clk); while (busy !== 1'b0);
    divisions_sent++;
    if (den == '0) zero_divisors++;
    if (num == sdiv_pkg::MOST_NEG && den == sdiv_pkg::MINUS_ONE) overflow_cases++;
  endtask

  // Stops sending and waits until every outstanding quotient has come back.
  task automatic drain_quotients();
    start <= 1'b0;
    while (pending_quotients.size() != 0) @(posedge clk);
  endtask

  // Random operand with a spread of shapes: plain random words, small
  // values around zero, the boundary values, signed powers of two, and
  // random words cut down to a random number of significant bits, which
  // gives quotients of every length.
  function automatic logic signed [sdiv_pkg::WIDTH-1:0] random_operand();
    logic signed [sdiv_pkg::WIDTH-1:0] v;
    case ($urandom_range(0, 7))
      0: v = $signed($urandom_range(0, 32)) - 16;
      1: begin
        case ($urandom_range(0, 5))
          0: v = sdiv_pkg::MOST_NEG;
          1: v = sdiv_pkg::QUOT_MAX;
          2: v = '0;
          3: v = 1;
          4: v = sdiv_pkg::MINUS_ONE;
          default: v = sdiv_pkg::MOST_NEG + 1;
        endcase
      end
      2: begin
        v = 1 << $urandom_range(0, sdiv_pkg::WIDTH - 1);
        if ($urandom_range(0, 1)) v = '0 - v;
      end
      3, 4: begin
        v = $urandom >> $urandom_range(0, sdiv_pkg::WIDTH - 1);
        if ($urandom_range(0, 1)) v = '0 - v;
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Boundary operands and every special case: zero divisors of each sign
  // of dividend, the overflowing quotient, the most negative value over
  // plus one, dividends smaller than the divisor, and truncation toward
  // zero for each sign combination.
  task automatic test_directed_corners();
    send_division(0, 0);
    send_division(sdiv_pkg::QUOT_MAX, 0);
    send_division(sdiv_pkg::MOST_NEG, 0);
    send_division(-1, 0);
    send_division(sdiv_pkg::MOST_NEG, sdiv_pkg::MINUS_ONE);
    send_division(sdiv_pkg::MOST_NEG, 1);
    send_division(sdiv_pkg::MOST_NEG, sdiv_pkg::MOST_NEG);
    send_division(sdiv_pkg::MOST_NEG, sdiv_pkg::QUOT_MAX);
    send_division(sdiv_pkg::QUOT_MAX, sdiv_pkg::MOST_NEG);
    send_division(sdiv_pkg::QUOT_MAX, sdiv_pkg::QUOT_MAX);
    send_division(sdiv_pkg::QUOT_MAX, 1);
    send_division(sdiv_pkg::QUOT_MAX, sdiv_pkg::MINUS_ONE);
    send_division(sdiv_pkg::MOST_NEG, 2);
    send_division(sdiv_pkg::MOST_NEG, -2);
    send_division(-1, sdiv_pkg::MOST_NEG);
    send_division(5, 7);
    send_division(-5, 7);
    send_division(0, -3);
    send_division(7, 2);
    send_division(-7, 2);
    send_division(7, -2);
    send_division(-7, -2);
    send_division(1, 1);
    send_division(100, -100);
    drain_quotients();
  endtask

  // The bulk of the run, with the sender pausing at random.
  task automatic test_random_with_idles(input int count);
    sender_idles = 1'b1;
    repeat (count) send_division(random_operand(), random_operand());
    sender_idles = 1'b0;
    drain_quotients();
  endtask

  // Commands offered every cycle, so each one is taken in the same cycle
  // that the previous quotient comes out.
  task automatic test_random_back_to_back(input int count);
    repeat (count) send_division(random_operand(), random_operand());
    drain_quotients();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_corners();
    test_random_with_idles(850);
    test_random_back_to_back(380);
    // Let any stray strobe that might follow the last quotient show up.
    repeat (40) @(posedge clk);
    $display("Ran %0d divisions and checked %0d quotients, with %0d zero divisors",
             divisions_sent, quotients_checked, zero_divisors);
    $display("and %0d overflowing cases; %0d mismatches.", overflow_cases, mismatch_count);
    if (mismatch_count == 0 && pending_quotients.size() == 0) begin
      $display("tb_signed_divider_saturating OK");
    end else begin
      $display("tb_signed_divider_saturating NOT OK");
    end
    $finish;
  end

  // Watchdog: well beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("Timed out with %0d quotients outstanding.", pending_quotients.size());
    $display("tb_signed_divider_saturating NOT OK");
    $finish;
  end

endmodule

/* sim.f */
hdl/sdiv_pkg.sv
hdl/sdiv_dp.sv
hdl/sdiv_ctrl.sv
hdl/signed_divider_saturating.sv
test/tb_signed_divider_saturating.sv
